// ----- src/ssph_pkg.sv -----
`default_nettype none

package ssph_pkg;

    localparam int MAX_STEPS   = 64;
    localparam int STEP_W      = 6;
    localparam int LEN_W       = STEP_W + 1;
    localparam int MASK_W      = 64;
    localparam int RND_W       = 16;
    localparam int CNT_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int ALIGN_STEPS = STEP_W;
    localparam int DIV_STEPS   = RND_W;
    localparam int MASK_BYTES  = MASK_W / 8;

    localparam logic [CNT_W-1:0] ALIGN_LAST = CNT_W'(ALIGN_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] COUNT_LAST = CNT_W'(MASK_BYTES - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_ORDER     = 2'd2;

    localparam logic [3:0] ACT_PULSE    = 4'd0;
    localparam logic [3:0] ACT_PLAY     = 4'd1;
    localparam logic [3:0] ACT_CONTINUE = 4'd2;
    localparam logic [3:0] ACT_STOP     = 4'd3;
    localparam logic [3:0] ACT_BACK     = 4'd4;
    localparam logic [3:0] ACT_FORWARD  = 4'd5;
    localparam logic [3:0] ACT_CUE      = 4'd6;
    localparam logic [3:0] ACT_PRESS    = 4'd7;
    localparam logic [3:0] ACT_RELEASE  = 4'd8;

    localparam logic [2:0] ORD_PAUSE    = 3'd0;
    localparam logic [2:0] ORD_FORWARD  = 3'd1;
    localparam logic [2:0] ORD_BACKWARD = 3'd2;
    localparam logic [2:0] ORD_PINGPONG = 3'd3;
    localparam logic [2:0] ORD_PPREPEAT = 3'd4;
    localparam logic [2:0] ORD_SHUFFLE  = 3'd5;

    localparam logic [1:0] RUN_IDLE    = 2'd0;
    localparam logic [1:0] RUN_PLAYING = 2'd1;
    localparam logic [1:0] RUN_PREVIEW = 2'd2;
    localparam logic [1:0] RUN_FINISH  = 2'd3;

    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_START    = 2'd1;
    localparam logic [1:0] EV_CONTINUE = 2'd2;
    localparam logic [1:0] EV_STOP     = 2'd3;

    localparam logic [STEP_W-1:0] WRAP_LO [32] = '{
        6'd0,  6'd0,  6'd1,  6'd0,  6'd3,  6'd3,  6'd3,  6'd0,
        6'd7,  6'd0,  6'd3,  6'd8,  6'd3,  6'd11, 6'd7,  6'd3,
        6'd15, 6'd12, 6'd9,  6'd6,  6'd3,  6'd0,  6'd19, 6'd17,
        6'd15, 6'd13, 6'd11, 6'd9,  6'd7,  6'd5,  6'd3,  6'd1
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_EXEC,
        ST_COUNT,
        ST_DIVLOAD,
        ST_DIVIDE,
        ST_FBYTE,
        ST_FBIT,
        ST_MODIDX,
        ST_FINISH,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV,
        OP_EXEC,
        OP_COUNT,
        OP_DIVLOAD,
        OP_FBYTE,
        OP_FBIT,
        OP_FINISH,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] byte_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic shuffle_go;
        logic byte_hit;
        logic bit_hit;
        logic out_free;
    } dp_status_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] pl);
        logic [LEN_W-1:0] l;
        l = pl;
        if (l == '0)
        begin
            l = LEN_W'(1);
        end
        if (l > LEN_W'(MAX_STEPS))
        begin
            l = LEN_W'(MAX_STEPS);
        end
        return l;
    endfunction

    // 63 mod len: where a backward step from the loop start lands
    function automatic logic [STEP_W-1:0] back_wrap(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] d;
        d = LEN_W'(63) - len;
        if (len >= LEN_W'(64))
        begin
            return STEP_W'(63);
        end
        else if (len >= LEN_W'(32))
        begin
            return d[STEP_W-1:0];
        end
        else
        begin
            return WRAP_LO[len[4:0]];
        end
    endfunction

    function automatic logic [STEP_W-1:0] rel_inc(input logic [STEP_W-1:0] r,
                                                  input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] n;
        n = {1'b0, r} + LEN_W'(1);
        return (n >= len) ? '0 : n[STEP_W-1:0];
    endfunction

    function automatic logic [STEP_W-1:0] rel_dec(input logic [STEP_W-1:0] r,
                                                  input logic [LEN_W-1:0] len);
        return (r == '0) ? back_wrap(len) : r - STEP_W'(1);
    endfunction

    function automatic logic [3:0] popcount8(input logic [7:0] b);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + {3'b000, b[i]};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/ssph_ctrl.sv -----
`default_nettype none

module ssph_ctrl
    import ssph_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + CNT_W'(1);
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN:
            begin
                if (cnt_reg == ALIGN_LAST)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cnt_next = '0;
                state_next = status.shuffle_go ? ST_COUNT : ST_EMIT;
            end
            ST_COUNT:
            begin
                if (cnt_reg == COUNT_LAST)
                begin
                    state_next = ST_DIVLOAD;
                end
            end
            ST_DIVLOAD:
            begin
                cnt_next   = '0;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_FBYTE;
                end
            end
            ST_FBYTE:
            begin
                if (status.byte_hit)
                begin
                    state_next = ST_FBIT;
                end
            end
            ST_FBIT:
            begin
                cnt_next = '0;
                if (status.bit_hit)
                begin
                    state_next = ST_MODIDX;
                end
            end
            ST_MODIDX:
            begin
                if (cnt_reg == ALIGN_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b1;
        cmd.op       = OP_NONE;
        cmd.byte_sel = cnt_reg[2:0];
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_ALIGN:   cmd.op = OP_DIV;
            ST_EXEC:    cmd.op = OP_EXEC;
            ST_COUNT:   cmd.op = OP_COUNT;
            ST_DIVLOAD: cmd.op = OP_DIVLOAD;
            ST_DIVIDE:  cmd.op = OP_DIV;
            ST_FBYTE:   cmd.op = OP_FBYTE;
            ST_FBIT:    cmd.op = OP_FBIT;
            ST_MODIDX:  cmd.op = OP_DIV;
            ST_FINISH:  cmd.op = OP_FINISH;
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op = OP_EMIT;
                end
            end
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/ssph_dpath.sv -----
`default_nettype none

module ssph_dpath
    import ssph_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [3:0]            action,
    input  wire logic                  advance_allowed,
    input  wire logic [RND_W-1:0]      random_value,
    input  wire logic [STEP_W-1:0]     target_step,
    input  wire logic                  short_press,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [STEP_W-1:0]          playhead_step,
    output logic [STEP_W-1:0]          effective_start,
    output logic [1:0]                 run_state,
    output logic                       wrapped,
    output logic [1:0]                 transport_event,
    output logic                       cue_pending,
    output logic [STEP_W-1:0]          cued_start,
    output logic                       going_backwards
);

    typedef struct packed {
        logic play;
        logic prev;
        logic stop;
        logic manual;
        logic first;
        logic back;
    } flags_t;

    logic [LEN_W-1:0]  pattern_length_reg;
    logic [STEP_W-1:0] start_offset_reg;
    logic [2:0]        play_order_reg;

    logic [3:0]        action_reg;
    logic              allowed_reg;
    logic [RND_W-1:0]  random_reg;
    logic [STEP_W-1:0] target_reg;
    logic              short_reg;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] start_reg;
    logic [STEP_W-1:0] start_next;
    logic              pv_reg;
    logic              pv_next;
    logic [STEP_W-1:0] pstep_reg;
    logic [STEP_W-1:0] pstep_next;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    flags_t            flags_reg;
    flags_t            flags_next;
    logic              wrap_reg;
    logic              wrap_next;
    logic [1:0]        event_reg;
    logic [1:0]        event_next;

    logic [RND_W-1:0]  quo_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  den_reg;
    logic [LEN_W-1:0]  acc_reg;
    logic [STEP_W-1:0] scan_reg;
    logic [LEN_W-1:0]  run_reg;

    logic              out_valid_reg;

    logic [LEN_W-1:0]  len;
    logic [STEP_W-1:0] eff_cur;
    logic [STEP_W-1:0] rel_cur;
    logic [LEN_W-1:0]  div_shift;
    logic [LEN_W-1:0]  div_rem;
    logic [3:0]        scan_pc;
    logic [3:0]        count_pc;
    logic              byte_hit;
    logic              bit_hit;
    logic              shuffle_go;
    logic [STEP_W-1:0] rel_w;
    logic [STEP_W-1:0] cue_ns;
    logic [MASK_W-1:0] mask_fill;
    logic [1:0]        run_code;

    assign len       = clamp_len(pattern_length_reg);
    assign eff_cur   = start_reg + start_offset_reg;
    assign rel_cur   = step_reg - eff_cur;
    assign div_shift = {rem_reg[STEP_W-1:0], quo_reg[RND_W-1]};
    assign div_rem   = (div_shift >= den_reg) ? div_shift - den_reg : div_shift;
    assign scan_pc   = popcount8(mask_reg[{scan_reg[5:3], 3'b000} +: 8]);
    assign count_pc  = popcount8(mask_reg[{cmd.byte_sel, 3'b000} +: 8]);
    assign byte_hit  = ({1'b0, run_reg} + {4'b0000, scan_pc}) > {1'b0, rem_reg};
    assign bit_hit   = mask_reg[scan_reg] && (run_reg == rem_reg);
    assign cue_ns    = target_reg - start_offset_reg;
    assign mask_fill = ~({MASK_W{1'b1}} << len);

    always_comb
    begin
        flags_next = flags_reg;
        start_next = start_reg;
        pv_next    = pv_reg;
        pstep_next = pstep_reg;
        mask_next  = mask_reg;
        wrap_next  = wrap_reg;
        event_next = event_reg;
        rel_w      = rem_reg[STEP_W-1:0];
        shuffle_go = 1'b0;
        step_next  = step_reg;
        case (cmd.op)
            OP_EXEC:
            begin
                wrap_next  = 1'b0;
                event_next = EV_NONE;
                case (action_reg)
                    ACT_PULSE:
                    begin
                        if (flags_next.play || flags_next.manual)
                        begin
                            flags_next.manual = 1'b0;
                            if (!allowed_reg || flags_next.first)
                            begin
                                flags_next.first = 1'b0;
                            end
                            else if (play_order_reg == ORD_SHUFFLE)
                            begin
                                shuffle_go = 1'b1;
                                if (mask_next == '0)
                                begin
                                    mask_next = mask_fill;
                                    wrap_next = 1'b1;
                                end
                            end
                            else
                            begin
                                case (play_order_reg)
                                    ORD_FORWARD:
                                    begin
                                        wrap_next = rel_inc(rel_w, len) <= rel_w;
                                        rel_w     = rel_inc(rel_w, len);
                                    end
                                    ORD_BACKWARD:
                                    begin
                                        wrap_next = rel_dec(rel_w, len) >= rel_w;
                                        rel_w     = rel_dec(rel_w, len);
                                    end
                                    ORD_PINGPONG, ORD_PPREPEAT:
                                    begin
                                        if ((!flags_next.back &&
                                             {1'b0, rel_w} >= len - LEN_W'(1)) ||
                                            (flags_next.back && rel_w == '0))
                                        begin
                                            flags_next.back = !flags_next.back;
                                            wrap_next       = 1'b1;
                                        end
                                        if (wrap_next && play_order_reg == ORD_PPREPEAT)
                                        begin
                                            rel_w = flags_next.back ?
                                                    STEP_W'(len - LEN_W'(1)) : '0;
                                        end
                                        else if (flags_next.back)
                                        begin
                                            rel_w = rel_dec(rel_w, len);
                                        end
                                        else
                                        begin
                                            rel_w = rel_inc(rel_w, len);
                                        end
                                    end
                                    default:
                                    begin
                                        rel_w = rel_w;
                                    end
                                endcase
                                if (wrap_next && pv_next)
                                begin
                                    start_next = pstep_next;
                                    pv_next    = 1'b0;
                                end
                                if (flags_next.play && flags_next.stop)
                                begin
                                    event_next      = EV_STOP;
                                    flags_next.play = 1'b0;
                                    flags_next.prev = 1'b0;
                                    flags_next.stop = 1'b0;
                                    if (pv_next)
                                    begin
                                        start_next = pstep_next;
                                        pv_next    = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                    ACT_PLAY, ACT_CONTINUE:
                    begin
                        if (action_reg == ACT_PLAY)
                        begin
                            mask_next       = '0;
                            flags_next.back = 1'b0;
                            rel_w           = '0;
                        end
                        if (pv_next)
                        begin
                            start_next = pstep_next;
                            pv_next    = 1'b0;
                        end
                        flags_next.first = 1'b1;
                        if (!flags_next.play)
                        begin
                            flags_next.play = 1'b1;
                            event_next = (rel_w == '0) ? EV_START : EV_CONTINUE;
                        end
                    end
                    ACT_STOP:
                    begin
                        event_next      = EV_STOP;
                        flags_next.play = 1'b0;
                        flags_next.prev = 1'b0;
                        flags_next.stop = 1'b0;
                        if (pv_next)
                        begin
                            start_next = pstep_next;
                            pv_next    = 1'b0;
                        end
                    end
                    ACT_BACK:
                    begin
                        if (!flags_next.play)
                        begin
                            rel_w             = rel_dec(rel_w, len);
                            flags_next.manual = 1'b1;
                            flags_next.first  = 1'b1;
                        end
                    end
                    ACT_FORWARD:
                    begin
                        rel_w             = rel_inc(rel_w, len);
                        flags_next.manual = 1'b1;
                        flags_next.first  = 1'b1;
                    end
                    ACT_CUE:
                    begin
                        if (!flags_next.play || (pv_next && pstep_next == cue_ns))
                        begin
                            start_next = cue_ns;
                            pv_next    = 1'b0;
                        end
                        else
                        begin
                            pv_next    = 1'b1;
                            pstep_next = cue_ns;
                        end
                    end
                    ACT_PRESS:
                    begin
                        if (flags_next.play)
                        begin
                            if (!flags_next.stop)
                            begin
                                flags_next.stop = 1'b1;
                            end
                            else
                            begin
                                event_next      = EV_STOP;
                                flags_next.play = 1'b0;
                                flags_next.prev = 1'b0;
                                flags_next.stop = 1'b0;
                                if (pv_next)
                                begin
                                    start_next = pstep_next;
                                    pv_next    = 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            flags_next.prev = 1'b1;
                            if (pv_next)
                            begin
                                start_next = pstep_next;
                                pv_next    = 1'b0;
                            end
                            flags_next.first = 1'b1;
                            flags_next.play  = 1'b1;
                            event_next = (rel_w == '0) ? EV_START : EV_CONTINUE;
                        end
                    end
                    ACT_RELEASE:
                    begin
                        if (flags_next.prev)
                        begin
                            if (short_reg)
                            begin
                                flags_next.prev = 1'b0;
                            end
                            else
                            begin
                                event_next      = EV_STOP;
                                flags_next.play = 1'b0;
                                flags_next.prev = 1'b0;
                                flags_next.stop = 1'b0;
                                if (pv_next)
                                begin
                                    start_next = pstep_next;
                                    pv_next    = 1'b0;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        rel_w = rel_w;
                    end
                endcase
                step_next = start_next + start_offset_reg + rel_w;
            end
            OP_FINISH:
            begin
                mask_next  = mask_reg & ~({{(MASK_W-1){1'b0}}, 1'b1} << scan_reg);
                event_next = EV_NONE;
                if (wrap_reg && pv_next)
                begin
                    start_next = pstep_next;
                    pv_next    = 1'b0;
                end
                if (flags_next.play && flags_next.stop)
                begin
                    event_next      = EV_STOP;
                    flags_next.play = 1'b0;
                    flags_next.prev = 1'b0;
                    flags_next.stop = 1'b0;
                    if (pv_next)
                    begin
                        start_next = pstep_next;
                        pv_next    = 1'b0;
                    end
                end
                step_next = start_next + start_offset_reg + rel_w;
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_comb
    begin
        if (!flags_reg.play)
        begin
            run_code = RUN_IDLE;
        end
        else if (flags_reg.prev)
        begin
            run_code = RUN_PREVIEW;
        end
        else if (flags_reg.stop)
        begin
            run_code = RUN_FINISH;
        end
        else
        begin
            run_code = RUN_PLAYING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= LEN_W'(MAX_STEPS);
            start_offset_reg   <= '0;
            play_order_reg     <= ORD_FORWARD;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                CFG_START_OFFSET:   start_offset_reg   <= cfg_data[STEP_W-1:0];
                CFG_PLAY_ORDER:     play_order_reg     <= cfg_data[2:0];
                default:            play_order_reg     <= play_order_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            start_reg     <= '0;
            pv_reg        <= 1'b0;
            mask_reg      <= '0;
            flags_reg     <= '0;
            wrap_reg      <= 1'b0;
            event_reg     <= EV_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            start_reg <= start_next;
            pv_reg    <= pv_next;
            mask_reg  <= mask_next;
            flags_reg <= flags_next;
            wrap_reg  <= wrap_next;
            event_reg <= event_next;
            if (cmd.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pstep_reg <= pstep_next;
        case (cmd.op)
            OP_LOAD:
            begin
                action_reg  <= action;
                allowed_reg <= advance_allowed;
                random_reg  <= random_value;
                target_reg  <= target_step;
                short_reg   <= short_press;
                quo_reg     <= {rel_cur, {(RND_W-STEP_W){1'b0}}};
                rem_reg     <= '0;
                den_reg     <= len;
            end
            OP_DIV:
            begin
                quo_reg <= {quo_reg[RND_W-2:0], 1'b0};
                rem_reg <= div_rem;
            end
            OP_EXEC:
            begin
                acc_reg <= '0;
            end
            OP_COUNT:
            begin
                acc_reg <= acc_reg + {3'b000, count_pc};
            end
            OP_DIVLOAD:
            begin
                quo_reg  <= random_reg;
                rem_reg  <= '0;
                den_reg  <= acc_reg;
                scan_reg <= '0;
                run_reg  <= '0;
            end
            OP_FBYTE:
            begin
                if (!byte_hit)
                begin
                    run_reg  <= run_reg + {3'b000, scan_pc};
                    scan_reg <= {scan_reg[5:3] + 3'd1, 3'b000};
                end
            end
            OP_FBIT:
            begin
                if (bit_hit)
                begin
                    quo_reg <= {scan_reg, {(RND_W-STEP_W){1'b0}}};
                    rem_reg <= '0;
                    den_reg <= len;
                end
                else
                begin
                    run_reg  <= run_reg + {{(LEN_W-1){1'b0}}, mask_reg[scan_reg]};
                    scan_reg <= scan_reg + STEP_W'(1);
                end
            end
            OP_EMIT:
            begin
                playhead_step   <= step_reg;
                effective_start <= eff_cur;
                run_state       <= run_code;
                wrapped         <= wrap_reg;
                transport_event <= event_reg;
                cue_pending     <= pv_reg;
                cued_start      <= pv_reg ? pstep_reg : '0;
                going_backwards <= flags_reg.back;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign out_valid         = out_valid_reg;
    assign status.shuffle_go = shuffle_go;
    assign status.byte_hit   = byte_hit;
    assign status.bit_hit    = bit_hit;
    assign status.out_free   = !out_valid_reg || !out_stall;

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DIV) |-> (den_reg != '0))
        else $error("divider runs with a zero divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DIV) |-> (rem_reg < den_reg))
        else $error("partial remainder not below divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_COUNT) |-> (mask_reg != '0))
        else $error("shuffle count over an empty mask");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FBYTE && !byte_hit) |-> (scan_reg[5:3] != 3'd7))
        else $error("shuffle byte search ran past the last byte");

endmodule

`default_nettype wire

// ----- src/step_sequencer_playhead_core.sv -----
// Playhead of a 64-step pattern sequencer.
// Request channel: in_valid / in_stall carry one transport action (pulse, play,
// continue, stop, back, forward, cue start, press play, release play) with its
// gate bit, random value, target step and press length. A request is taken when
// in_valid is high and in_stall is low; in_stall is low only while the block
// waits for work.
// Result channel: out_valid / out_stall carry exactly one result per request:
// step, modulated start, run state, wrap flag, transport event, cue state and
// ping-pong direction. A result register separates the channels, so the next
// request is taken while a result still waits for out_stall to drop.
// Timing: each request first realigns the step with the shared remainder
// unit, then executes its action. Non-shuffle requests then emit their result;
// no new request is taken until the block is back in idle. A shuffle pulse adds
// a byte-wise popcount of the mask, a remainder of the random value by that
// count, a free-step search byte by byte and then bit by bit, and a remainder
// by the length. A stalled receiver holds the block in its emit step.
// Configuration: cfg_write with cfg_index 0 length, 1 start offset, 2 order;
// writes are for idle periods and take effect at the next request.
// Reset (rst_n low, asynchronous) clears step, start, cue, shuffle mask and run
// flags, and sets length 64, offset 0, order forward.
`default_nettype none

module step_sequencer_playhead_core
    import ssph_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [3:0]            action,
    input  wire logic                  advance_allowed,
    input  wire logic [RND_W-1:0]      random_value,
    input  wire logic [STEP_W-1:0]     target_step,
    input  wire logic                  short_press,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [STEP_W-1:0]          playhead_step,
    output logic [STEP_W-1:0]          effective_start,
    output logic [1:0]                 run_state,
    output logic                       wrapped,
    output logic [1:0]                 transport_event,
    output logic                       cue_pending,
    output logic [STEP_W-1:0]          cued_start,
    output logic                       going_backwards
);

    dp_cmd_t    cmd;
    dp_status_t status;

    ssph_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ssph_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .action          (action),
        .advance_allowed (advance_allowed),
        .random_value    (random_value),
        .target_step     (target_step),
        .short_press     (short_press),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .playhead_step   (playhead_step),
        .effective_start (effective_start),
        .run_state       (run_state),
        .wrapped         (wrapped),
        .transport_event (transport_event),
        .cue_pending     (cue_pending),
        .cued_start      (cued_start),
        .going_backwards (going_backwards)
    );

endmodule

`default_nettype wire

// ----- tb/step_sequencer_playhead_core_tb.sv -----
`default_nettype none

module step_sequencer_playhead_core_tb;
    import ssph_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASES      = 16;

    typedef struct packed {
        logic [3:0]        act;
        logic              allow;
        logic [RND_W-1:0]  rnd;
        logic [STEP_W-1:0] target;
        logic              quick;
    } transport_req_t;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [STEP_W-1:0] start;
        logic [1:0]        run;
        logic              wrap;
        logic [1:0]        ev;
        logic              cue;
        logic [STEP_W-1:0] cue_at;
        logic              back;
    } playhead_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [3:0]            action = '0;
    logic                  advance_allowed = 1'b0;
    logic [RND_W-1:0]      random_value = '0;
    logic [STEP_W-1:0]     target_step = '0;
    logic                  short_press = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [STEP_W-1:0]     playhead_step;
    logic [STEP_W-1:0]     effective_start;
    logic [1:0]            run_state;
    logic                  wrapped;
    logic [1:0]            transport_event;
    logic                  cue_pending;
    logic [STEP_W-1:0]     cued_start;
    logic                  going_backwards;

    transport_req_t   action_queue [$];
    playhead_result_t expected_heads [$];

    int errors = 0;
    int requests_taken = 0;
    int results_checked = 0;
    int wraps_seen = 0;
    int stops_seen = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int rx_hold_req = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;
    int quiet_cycles = 0;

    // playhead state and register copies
    logic [STEP_W-1:0] hd_step = '0;
    logic [STEP_W-1:0] hd_start = '0;
    logic              cue_valid = 1'b0;
    logic [STEP_W-1:0] cue_step = '0;
    logic [63:0]       unplayed = '0;
    logic              playing = 1'b0;
    logic              previewing = 1'b0;
    logic              stop_armed = 1'b0;
    logic              manual_step = 1'b0;
    logic              skip_pulse = 1'b0;
    logic              descending = 1'b0;
    logic [1:0]        ev_now = EV_NONE;
    logic [6:0]        reg_len = 7'd64;
    logic [6:0]        reg_ofs = 7'd0;
    logic [2:0]        reg_order = ORD_FORWARD;

    step_sequencer_playhead_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .advance_allowed (advance_allowed),
        .random_value    (random_value),
        .target_step     (target_step),
        .short_press     (short_press),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .playhead_step   (playhead_step),
        .effective_start (effective_start),
        .run_state       (run_state),
        .wrapped         (wrapped),
        .transport_event (transport_event),
        .cue_pending     (cue_pending),
        .cued_start      (cued_start),
        .going_backwards (going_backwards)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int loop_steps();
        int l;
        l = reg_len;
        if (l < 1)
        begin
            l = 1;
        end
        if (l > MAX_STEPS)
        begin
            l = MAX_STEPS;
        end
        return l;
    endfunction

    function automatic logic [STEP_W-1:0] mod_start();
        return hd_start + reg_ofs[STEP_W-1:0];
    endfunction

    function automatic logic [STEP_W-1:0] rel_step();
        return hd_step - mod_start();
    endfunction

    function automatic void realign();
        hd_step = mod_start() + STEP_W'(int'(rel_step()) % loop_steps());
    endfunction

    function automatic void put_step(input logic [STEP_W-1:0] s);
        hd_step = s;
        realign();
    endfunction

    function automatic void set_start(input logic [STEP_W-1:0] n);
        logic [STEP_W-1:0] r;
        r = rel_step();
        hd_start = n;
        put_step(mod_start() + r);
    endfunction

    function automatic void apply_cue();
        if (cue_valid)
        begin
            set_start(cue_step);
            cue_valid = 1'b0;
            cue_step = '0;
        end
        realign();
    endfunction

    function automatic bit step_up();
        logic [STEP_W-1:0] r0;
        r0 = rel_step();
        put_step(hd_step + STEP_W'(1));
        return rel_step() <= r0;
    endfunction

    function automatic bit step_down();
        logic [STEP_W-1:0] r0;
        r0 = rel_step();
        put_step(hd_step - STEP_W'(1));
        return rel_step() >= r0;
    endfunction

    function automatic void halt_transport();
        ev_now = EV_STOP;
        previewing = 1'b0;
        playing = 1'b0;
        stop_armed = 1'b0;
        apply_cue();
    endfunction

    function automatic void resume_play();
        apply_cue();
        skip_pulse = 1'b1;
        if (!playing)
        begin
            playing = 1'b1;
            ev_now = (hd_step == mod_start()) ? EV_START : EV_CONTINUE;
        end
    endfunction

    function automatic void restart_play();
        unplayed = '0;
        descending = 1'b0;
        put_step(mod_start());
        resume_play();
    endfunction

    function automatic bit shuffle_pick(input logic [RND_W-1:0] rnd);
        int          len;
        int          cnt;
        int          pick;
        int          idx;
        logic [63:0] m;
        bit          refill;
        refill = 1'b0;
        len = loop_steps();
        if (unplayed == '0)
        begin
            unplayed = (len >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << len) - 64'd1);
            refill = 1'b1;
        end
        m = unplayed;
        cnt = $countones(m);
        pick = int'(rnd) % cnt;
        repeat (pick) m = m & (m - 64'd1);
        idx = 0;
        while (idx < 63 && !m[idx])
        begin
            idx++;
        end
        put_step(mod_start() + STEP_W'(idx));
        unplayed[idx] = 1'b0;
        return refill;
    endfunction

    function automatic bit pulse_advance(input logic allow, input logic [RND_W-1:0] rnd);
        bit                w;
        int                len;
        int                r;
        logic [STEP_W-1:0] far_end;
        w = 1'b0;
        if (!playing && !manual_step)
        begin
            return 1'b0;
        end
        manual_step = 1'b0;
        if (!allow || skip_pulse)
        begin
            skip_pulse = 1'b0;
            return 1'b0;
        end
        len = loop_steps();
        case (reg_order)
            ORD_FORWARD:  w = step_up();
            ORD_BACKWARD: w = step_down();
            ORD_PINGPONG, ORD_PPREPEAT:
            begin
                r = rel_step();
                if ((!descending && r >= len - 1) || (descending && r == 0))
                begin
                    descending = !descending;
                    w = 1'b1;
                    if (reg_order == ORD_PPREPEAT)
                    begin
                        far_end = mod_start() + STEP_W'(len - 1);
                        put_step(descending ? far_end : mod_start());
                    end
                end
                if (!(w && reg_order == ORD_PPREPEAT))
                begin
                    if (descending)
                    begin
                        void'(step_down());
                    end
                    else
                    begin
                        void'(step_up());
                    end
                end
            end
            ORD_SHUFFLE:  w = shuffle_pick(rnd);
            default:      ;
        endcase
        if (w)
        begin
            apply_cue();
        end
        if (playing && stop_armed)
        begin
            halt_transport();
        end
        return w;
    endfunction

    task automatic predict_playhead(input transport_req_t req, output playhead_result_t res);
        bit                w;
        logic [STEP_W-1:0] ns;
        w = 1'b0;
        ev_now = EV_NONE;
        realign();
        case (req.act)
            ACT_PULSE:    w = pulse_advance(req.allow, req.rnd);
            ACT_PLAY:     restart_play();
            ACT_CONTINUE: resume_play();
            ACT_STOP:     halt_transport();
            ACT_BACK:
            begin
                if (!playing)
                begin
                    void'(step_down());
                    manual_step = 1'b1;
                    skip_pulse = 1'b1;
                end
            end
            ACT_FORWARD:
            begin
                void'(step_up());
                manual_step = 1'b1;
                skip_pulse = 1'b1;
            end
            ACT_CUE:
            begin
                ns = req.target - reg_ofs[STEP_W-1:0];
                if (!playing || (cue_valid && cue_step == ns))
                begin
                    if (mod_start() != req.target)
                    begin
                        set_start(ns);
                    end
                    cue_valid = 1'b0;
                    cue_step = '0;
                end
                else
                begin
                    cue_valid = 1'b1;
                    cue_step = ns;
                end
            end
            ACT_PRESS:
            begin
                if (playing)
                begin
                    if (!stop_armed)
                    begin
                        stop_armed = 1'b1;
                    end
                    else
                    begin
                        halt_transport();
                    end
                end
                else
                begin
                    previewing = 1'b1;
                    resume_play();
                end
            end
            ACT_RELEASE:
            begin
                if (previewing)
                begin
                    if (req.quick)
                    begin
                        previewing = 1'b0;
                    end
                    else
                    begin
                        halt_transport();
                    end
                end
            end
            default: ;
        endcase
        res.step = hd_step;
        res.start = mod_start();
        res.run = !playing ? RUN_IDLE : previewing ? RUN_PREVIEW :
                  stop_armed ? RUN_FINISH : RUN_PLAYING;
        res.wrap = w;
        res.ev = ev_now;
        res.cue = cue_valid;
        res.cue_at = cue_valid ? cue_step : '0;
        res.back = descending;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        transport_req_t   req;
        playhead_result_t res;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= '0;
            advance_allowed <= 1'b0;
            random_value <= '0;
            target_step <= '0;
            short_press <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                req.act = action;
                req.allow = advance_allowed;
                req.rnd = random_value;
                req.target = target_step;
                req.quick = short_press;
                predict_playhead(req, res);
                expected_heads.push_back(res);
                requests_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (action_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req = action_queue.pop_front();
                    in_valid <= 1'b1;
                    action <= req.act;
                    advance_allowed <= req.allow;
                    random_value <= req.rnd;
                    target_step <= req.target;
                    short_press <= req.quick;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        playhead_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_heads.size() == 0)
                begin
                    $display("%0t: result with no request waiting, step %0d", $time,
                             playhead_step);
                    errors++;
                end
                else
                begin
                    want = expected_heads.pop_front();
                    compare_field("playhead_step", want.step, playhead_step);
                    compare_field("effective_start", want.start, effective_start);
                    compare_field("run_state", want.run, run_state);
                    compare_field("wrapped", want.wrap, wrapped);
                    compare_field("transport_event", want.ev, transport_event);
                    compare_field("cue_pending", want.cue, cue_pending);
                    compare_field("cued_start", want.cue_at, cued_start);
                    compare_field("going_backwards", want.back, going_backwards);
                    results_checked++;
                    if (wrapped)
                    begin
                        wraps_seen++;
                    end
                    if (transport_event == EV_STOP)
                    begin
                        stops_seen++;
                    end
                end
            end
            if (rx_hold_req != rx_hold_seen)
            begin
                rx_hold_seen = rx_hold_req;
                rx_hold_left = LONG_HOLD;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_PATTERN_LENGTH: reg_len = val;
            CFG_START_OFFSET:   reg_ofs = val;
            CFG_PLAY_ORDER:     reg_order = val[2:0];
            default:            ;
        endcase
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (action_queue.size() != 0 || in_valid || expected_heads.size() != 0);
    endtask

    task automatic push_req(input logic [3:0] act, input logic allow, input logic [RND_W-1:0] rnd,
                            input logic [STEP_W-1:0] target, input logic quick);
        transport_req_t req;
        req.act = act;
        req.allow = allow;
        req.rnd = rnd;
        req.target = target;
        req.quick = quick;
        action_queue.push_back(req);
    endtask

    function automatic transport_req_t random_request();
        transport_req_t req;
        int             pick;
        pick = $urandom_range(99);
        req.allow = ($urandom_range(9) != 0);
        req.rnd = RND_W'($urandom);
        req.target = STEP_W'($urandom);
        req.quick = $urandom_range(1);
        if (pick < 58)
        begin
            req.act = ACT_PULSE;
        end
        else if (pick < 64)
        begin
            req.act = ACT_PLAY;
        end
        else if (pick < 68)
        begin
            req.act = ACT_CONTINUE;
        end
        else if (pick < 70)
        begin
            req.act = ACT_STOP;
        end
        else if (pick < 75)
        begin
            req.act = ACT_BACK;
        end
        else if (pick < 80)
        begin
            req.act = ACT_FORWARD;
        end
        else if (pick < 88)
        begin
            req.act = ACT_CUE;
        end
        else if (pick < 92)
        begin
            req.act = ACT_PRESS;
        end
        else if (pick < 97)
        begin
            req.act = ACT_RELEASE;
        end
        else
        begin
            req.act = 4'($urandom_range(15, 9));
        end
        return req;
    endfunction

    initial
    begin
        int lens [PHASES]   = '{64, 1, 8, 7, 64, 13, 0, 127, 64, 2, 1, 33, 5, 100, 64, 40};
        int offs [PHASES]   = '{0, 63, -63, 5, -1, 20, 0, -64, 31, -2, 10, 63, 1, -30, 0, -17};
        int orders [PHASES] = '{ORD_FORWARD, ORD_BACKWARD, ORD_PINGPONG, ORD_PPREPEAT,
                                ORD_SHUFFLE, ORD_SHUFFLE, ORD_FORWARD, ORD_BACKWARD,
                                ORD_PINGPONG, ORD_PPREPEAT, ORD_SHUFFLE, ORD_PAUSE,
                                6, 7, ORD_PPREPEAT, ORD_SHUFFLE};
        int count;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        push_req(ACT_STOP, 1'b1, 16'h0000, 6'd0, 1'b0);
        push_req(ACT_PULSE, 1'b1, 16'hFFFF, 6'd63, 1'b1);
        push_req(ACT_FORWARD, 1'b0, 16'h0000, 6'd0, 1'b0);
        push_req(ACT_PULSE, 1'b1, 16'h0000, 6'd0, 1'b0);
        push_req(ACT_PULSE, 1'b1, 16'h0000, 6'd0, 1'b0);
        push_req(ACT_BACK, 1'b0, 16'h0000, 6'd0, 1'b0);
        push_req(ACT_BACK, 1'b0, 16'h0000, 6'd0, 1'b0);
        push_req(ACT_CUE, 1'b0, 16'h0000, 6'd63, 1'b0);
        push_req(ACT_CUE, 1'b0, 16'h0000, 6'd0, 1'b0);
        push_req(ACT_PLAY, 1'b0, 16'h0000, 6'd0, 1'b0);
        push_req(ACT_PULSE, 1'b1, 16'h0000, 6'd0, 1'b0);
        push_req(ACT_PULSE, 1'b0, 16'h0000, 6'd0, 1'b0);
        push_req(ACT_PULSE, 1'b1, 16'hFFFF, 6'd0, 1'b0);
        push_req(ACT_BACK, 1'b0, 16'h0000, 6'd0, 1'b0);
        push_req(ACT_CUE, 1'b0, 16'h0000, 6'd20, 1'b0);
        push_req(ACT_CUE, 1'b0, 16'h0000, 6'd20, 1'b0);
        push_req(ACT_CUE, 1'b0, 16'h0000, 6'd40, 1'b0);
        push_req(ACT_PRESS, 1'b0, 16'h0000, 6'd0, 1'b0);
        push_req(ACT_PULSE, 1'b1, 16'h0000, 6'd0, 1'b0);
        push_req(ACT_CONTINUE, 1'b0, 16'h0000, 6'd0, 1'b0);
        push_req(ACT_PRESS, 1'b0, 16'h0000, 6'd0, 1'b0);
        push_req(ACT_PRESS, 1'b0, 16'h0000, 6'd0, 1'b0);
        push_req(ACT_PRESS, 1'b0, 16'h0000, 6'd0, 1'b0);
        push_req(ACT_RELEASE, 1'b0, 16'h0000, 6'd0, 1'b0);
        push_req(4'd15, 1'b1, 16'hFFFF, 6'd63, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(lens[p]));
            write_reg(CFG_START_OFFSET, CFG_DATA_W'(offs[p]));
            write_reg(CFG_PLAY_ORDER, CFG_DATA_W'(orders[p]));
            send_idle_pct = (p % 4 == 1) ? 66 : (p % 4 == 3) ? 24 : 0;
            recv_stall_pct = (p % 4 == 2) ? 66 : (p % 4 == 3) ? 24 : 0;
            // fill the block while the result side holds off
            if (p == 0)
            begin
                rx_hold_req++;
            end
            count = (p == 4) ? 160 : 96;
            push_req(ACT_PLAY, 1'b1, RND_W'($urandom), STEP_W'($urandom), 1'b0);
            for (int i = 1; i < count; i++)
            begin
                action_queue.push_back(random_request());
            end
        end

        wait_drained();
        repeat (60) @(posedge clk);
        $display("Checked %0d results of %0d transport requests over %0d register settings",
                 results_checked, requests_taken, PHASES + 1);
        $display("(all play orders, lengths 0..127), with %0d loop wraps and %0d stop events",
                 wraps_seen, stops_seen);
        if (errors == 0 && expected_heads.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
src/ssph_pkg.sv
src/ssph_ctrl.sv
src/ssph_dpath.sv
src/step_sequencer_playhead_core.sv
tb/step_sequencer_playhead_core_tb.sv
